// ----- rtl/desp_pkg.sv -----
// Shared types and constants for the directory entry set parser.
`timescale 1ns / 1ps

package desp_pkg;

	// Entry type codes with the in-use bit stripped, but for ET_END, which is the full type byte.
	localparam logic [6:0] ET_PRIMARY = 7'h05;
	localparam logic [6:0] ET_STREAM  = 7'h40;
	localparam logic [6:0] ET_NAME    = 7'h41;
	localparam logic [7:0] ET_END     = 8'h00;

	localparam int ATTR_NO_LIST_BIT = 3;

	localparam logic [15:0] CHAR_NUL       = 16'h0000;
	localparam logic [15:0] CHAR_FIRST_PRN = 16'h0020;
	localparam logic [15:0] CHAR_LAST_PRN  = 16'h007E;
	localparam logic [7:0]  CHAR_SUBST     = 8'h3F;

	localparam int NAME_OUT_CHARS = 13;

	localparam logic [31:0] HASH_MUL  = 32'd2654435761;
	localparam logic [31:0] HASH_ADD  = 32'h9e3779b9;
	localparam logic [30:0] ID_SUBST  = 31'd2;

	localparam logic REG_PARENT_ID   = 1'b0;
	localparam logic REG_DIR_CLUSTER = 1'b1;

	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_STREAM = 2'd1,
		CLS_NAME   = 2'd2,
		CLS_OTHER  = 2'd3
	} ecls_t;

	typedef struct packed {
		logic [31:0] seed;
		logic [31:0] addc;
	} hash_seed_t;

	typedef struct packed {
		logic        kind;
		logic [30:0] child_id;
		logic [31:0] entry_index;
		logic [15:0] attrs;
		logic [7:0]  ext_flags;
		logic [31:0] start_clus;
		logic [63:0] byte_len;
		logic [3:0]  name_length;
		logic [63:0] name_low;
		logic [39:0] name_high;
	} rec_t;

endpackage

// ----- rtl/desp_if.sv -----
// Handshake channels for directory words and parsed records.
`timescale 1ns / 1ps

interface desp_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] dir_word;
	logic        dir_start;

	modport src(output valid, dir_word, dir_start, input ready);
	modport snk(input valid, dir_word, dir_start, output ready);
endinterface

interface desp_rec_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [30:0] child_id;
	logic [31:0] entry_index;
	logic [15:0] attrs;
	logic [7:0]  ext_flags;
	logic [31:0] start_clus;
	logic [63:0] byte_len;
	logic [3:0]  name_length;
	logic [63:0] name_low;
	logic [39:0] name_high;

	modport src(output valid, kind, child_id, entry_index, attrs, ext_flags,
		start_clus, byte_len, name_length, name_low, name_high, input ready);
	modport snk(input valid, kind, child_id, entry_index, attrs, ext_flags,
		start_clus, byte_len, name_length, name_low, name_high, output ready);
endinterface

// ----- rtl/desp_cfg.sv -----
// APB configuration registers and the precomputed child id hash seed.
`timescale 1ns / 1ps

module desp_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output desp_pkg::hash_seed_t   seed
);
	import desp_pkg::*;

	logic [31:0] parent_id_q;
	logic [31:0] dir_cluster_q;
	logic [31:0] prod;
	logic [31:0] seed_q;
	logic [31:0] addc_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parent_id_q   <= 32'd1;
			dir_cluster_q <= 32'd0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_PARENT_ID:   parent_id_q   <= pwdata;
				REG_DIR_CLUSTER: dir_cluster_q <= pwdata;
				default:         parent_id_q   <= parent_id_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PARENT_ID:   prdata = parent_id_q;
			REG_DIR_CLUSTER: prdata = dir_cluster_q;
			default:         prdata = 32'd0;
		endcase
	end

	// The seed only depends on the registers; after a write it settles through seed_q
	// and then addc_q.
	assign prod = 32'(dir_cluster_q * HASH_MUL);

	always_ff @(posedge clk) begin
		seed_q <= parent_id_q ^ prod;
		addc_q <= HASH_ADD + {seed_q[25:0], 6'd0} + {2'd0, seed_q[31:2]};
	end

	assign seed.seed = seed_q;
	assign seed.addc = addc_q;

endmodule

// ----- rtl/desp_parse.sv -----
// Per-word entry set decode: parse state, name capture and record assembly.
`timescale 1ns / 1ps

module desp_parse #(
	parameter int NAME_CAP = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	desp_word_if.snk             items,
	input  logic                 in_ready,
	input  desp_pkg::hash_seed_t seed,
	output logic                 push,
	output desp_pkg::rec_t       rec
);
	import desp_pkg::*;

	localparam int BUF_D = NAME_CAP - 1;
	localparam int SW    = $clog2(NAME_CAP);

	logic        accept;
	logic [63:0] w;

	logic [1:0]    wp_q, wp_n;
	ecls_t         cls_q, cls_n;
	logic          hp_q, hp_n;
	logic [7:0]    sl_q, sl_n;
	logic [31:0]   pat_q, pat_n;
	logic [31:0]   cnt_q, cnt_n;
	logic [15:0]   attrs_q, attrs_n;
	logic [7:0]    flags_q, flags_n;
	logic [31:0]   clus_q, clus_n;
	logic [63:0]   len_q, len_n;
	logic [7:0]    exp_q, exp_n;
	logic [SW-1:0] stored_q, stored_n;
	logic [7:0]    budget_q, budget_n;
	logic          halted_q, halted_n;
	logic          hs_q, hs_n;
	logic          done_q, done_n;
	logic [7:0]    nb_q [BUF_D];
	logic [7:0]    nb_n [BUF_D];

	logic [1:0]    pos;
	logic [15:0]   ch;
	logic [7:0]    ch_map;
	logic          take;
	logic          res_ok;
	logic          eod;

	logic [7:0]    nbpad [NAME_OUT_CHARS];
	logic [7:0]    nm    [NAME_OUT_CHARS];
	logic [31:0]   hval;

	assign items.ready = in_ready;
	assign accept      = items.valid & in_ready;
	assign w           = items.dir_word;

	always_comb begin
		wp_n     = wp_q;
		cls_n    = cls_q;
		hp_n     = hp_q;
		sl_n     = sl_q;
		pat_n    = pat_q;
		cnt_n    = cnt_q;
		attrs_n  = attrs_q;
		flags_n  = flags_q;
		clus_n   = clus_q;
		len_n    = len_q;
		exp_n    = exp_q;
		stored_n = stored_q;
		budget_n = budget_q;
		halted_n = halted_q;
		hs_n     = hs_q;
		done_n   = done_q;
		nb_n     = nb_q;
		pos      = 2'd0;
		ch       = CHAR_NUL;
		ch_map   = 8'd0;
		take     = 1'b0;
		res_ok   = 1'b0;
		eod      = 1'b0;

		if (items.dir_start) begin
			wp_n     = 2'd0;
			cls_n    = CLS_NONE;
			hp_n     = 1'b0;
			sl_n     = 8'd0;
			pat_n    = 32'd0;
			cnt_n    = 32'd0;
			attrs_n  = 16'd0;
			flags_n  = 8'd0;
			clus_n   = 32'd0;
			len_n    = 64'd0;
			exp_n    = 8'd0;
			stored_n = '0;
			budget_n = 8'd0;
			halted_n = 1'b0;
			hs_n     = 1'b0;
			done_n   = 1'b0;
		end

		if (!done_n) begin
			pos  = wp_n;
			wp_n = wp_n + 2'd1;

			if (pos == 2'd0) begin
				cls_n = CLS_NONE;
				if (w[7:0] == ET_END) begin
					done_n = 1'b1;
					eod    = 1'b1;
				end else if (!w[7]) begin
					// An unused entry drops whatever set was open.
					hp_n = 1'b0;
					sl_n = 8'd0;
				end else if (w[6:0] == ET_PRIMARY) begin
					hp_n     = 1'b1;
					sl_n     = w[15:8];
					pat_n    = cnt_n;
					attrs_n  = w[47:32];
					flags_n  = 8'd0;
					clus_n   = 32'd0;
					len_n    = 64'd0;
					exp_n    = 8'd0;
					stored_n = '0;
					hs_n     = 1'b0;
				end else if (!hp_n || sl_n == 8'd0) begin
					cls_n = CLS_NONE;
				end else if (w[6:0] == ET_STREAM) begin
					cls_n   = CLS_STREAM;
					flags_n = w[15:8];
					exp_n   = w[31:24];
					hs_n    = 1'b1;
				end else if (w[6:0] == ET_NAME) begin
					cls_n    = CLS_NAME;
					budget_n = (exp_n > 8'(stored_n)) ? exp_n - 8'(stored_n) : 8'd0;
					halted_n = 1'b0;
					take     = 1'b1;
				end else begin
					cls_n = CLS_OTHER;
				end
			end else begin
				if (cls_n == CLS_STREAM) begin
					if (pos == 2'd2) begin
						clus_n = w[63:32];
					end else if (pos == 2'd3) begin
						len_n = w;
					end
				end else if (cls_n == CLS_NAME) begin
					take = 1'b1;
				end
			end

			// Up to four 16-bit characters per word; the first slot of word 0
			// holds the type and flags bytes.
			if (take) begin
				for (int k = 0; k < 4; k++) begin
					if ((pos != 2'd0 || k != 0) && !halted_n && budget_n != 8'd0) begin
						ch = w[16*k +: 16];
						if (ch == CHAR_NUL) begin
							halted_n = 1'b1;
						end else begin
							ch_map = (ch >= CHAR_FIRST_PRN && ch <= CHAR_LAST_PRN) ?
								ch[7:0] : CHAR_SUBST;
							if (stored_n < SW'(BUF_D)) begin
								for (int j = 0; j < BUF_D; j++) begin
									if (stored_n == SW'(j)) begin
										nb_n[j] = ch_map;
									end
								end
								stored_n = stored_n + SW'(1);
							end
							budget_n = budget_n - 8'd1;
						end
					end
				end
			end

			if (pos == 2'd3) begin
				if (cls_n != CLS_NONE && hp_n && sl_n != 8'd0) begin
					sl_n = sl_n - 8'd1;
					if (sl_n == 8'd0 && hs_n) begin
						if (stored_n != '0 && !attrs_n[ATTR_NO_LIST_BIT]) begin
							res_ok = 1'b1;
						end
						hp_n = 1'b0;
					end
				end
				cls_n = CLS_NONE;
				cnt_n = cnt_n + 32'd1;
			end
		end
	end

	for (genvar g = 0; g < NAME_OUT_CHARS; g++) begin : g_pad
		if (g < BUF_D) begin : g_buf
			assign nbpad[g] = nb_n[g];
		end else begin : g_zero
			assign nbpad[g] = 8'd0;
		end
	end

	always_comb begin
		for (int i = 0; i < NAME_OUT_CHARS; i++) begin
			nm[i] = (i < int'(stored_n)) ? nbpad[i] : 8'd0;
		end
	end

	// A record only forms on the fourth word of an entry, where the primary
	// index has not moved since the last word 0.
	assign hval = seed.seed ^ (pat_q + seed.addc);

	always_comb begin
		rec  = '0;
		push = accept & (eod | res_ok);
		if (eod) begin
			rec.kind = 1'b1;
		end else begin
			rec.kind          = 1'b0;
			rec.child_id      = (hval[30:0] == 31'd0) ? ID_SUBST : hval[30:0];
			rec.entry_index   = pat_q;
			rec.attrs         = attrs_n;
			rec.ext_flags     = flags_n;
			rec.start_clus    = clus_n;
			rec.byte_len      = len_n;
			rec.name_length   = 4'(stored_n);
			rec.name_low      = {nm[7], nm[6], nm[5], nm[4], nm[3], nm[2], nm[1], nm[0]};
			rec.name_high     = {nm[12], nm[11], nm[10], nm[9], nm[8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= 2'd0;
			cls_q    <= CLS_NONE;
			hp_q     <= 1'b0;
			sl_q     <= 8'd0;
			pat_q    <= 32'd0;
			cnt_q    <= 32'd0;
			attrs_q  <= 16'd0;
			flags_q  <= 8'd0;
			clus_q   <= 32'd0;
			len_q    <= 64'd0;
			exp_q    <= 8'd0;
			stored_q <= '0;
			budget_q <= 8'd0;
			halted_q <= 1'b0;
			hs_q     <= 1'b0;
			done_q   <= 1'b0;
		end else if (accept) begin
			wp_q     <= wp_n;
			cls_q    <= cls_n;
			hp_q     <= hp_n;
			sl_q     <= sl_n;
			pat_q    <= pat_n;
			cnt_q    <= cnt_n;
			attrs_q  <= attrs_n;
			flags_q  <= flags_n;
			clus_q   <= clus_n;
			len_q    <= len_n;
			exp_q    <= exp_n;
			stored_q <= stored_n;
			budget_q <= budget_n;
			halted_q <= halted_n;
			hs_q     <= hs_n;
			done_q   <= done_n;
		end
	end

	// Name characters past the stored count are masked, so the buffer needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			nb_q <= nb_n;
		end
	end

endmodule

// ----- rtl/desp_skid.sv -----
// Result register with a skid stage in front of the record channel.
`timescale 1ns / 1ps

module desp_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  desp_pkg::rec_t rec,
	output logic           in_ready,
	desp_rec_if.src        records
);
	import desp_pkg::*;

	rec_t out_q;
	rec_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic pop;

	assign pop      = out_valid_q & records.ready;
	assign in_ready = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= rec;
			end else begin
				out_q <= rec;
			end
		end
	end

	assign records.valid         = out_valid_q;
	assign records.kind          = out_q.kind;
	assign records.child_id      = out_q.child_id;
	assign records.entry_index   = out_q.entry_index;
	assign records.attrs         = out_q.attrs;
	assign records.ext_flags     = out_q.ext_flags;
	assign records.start_clus    = out_q.start_clus;
	assign records.byte_len      = out_q.byte_len;
	assign records.name_length   = out_q.name_length;
	assign records.name_low      = out_q.name_low;
	assign records.name_high     = out_q.name_high;

endmodule

// ----- rtl/dir_entry_set_parser_top.sv -----
// Directory entry set parser: takes one 64-bit directory word per cycle when not stalled.
// Results: a record or end-of-directory beat is registered when the word that
// completes it is accepted, into the result register or, if that is full, the skid.
// Throughput: one word per cycle; the two-deep result buffer stalls input only
// when two results are waiting. Reset clears the parse state and the result
// buffer and sets parent_id to 1 and dir_cluster to 0; no clearing pass.
`timescale 1ns / 1ps

module dir_entry_set_parser_top #(
	parameter int NAME_CAP = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	desp_word_if.snk    items,
	desp_rec_if.src     records,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import desp_pkg::*;

	hash_seed_t seed;
	rec_t       rec;
	logic       push;
	logic       in_ready;

	desp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.seed    (seed)
	);

	desp_parse #(
		.NAME_CAP (NAME_CAP)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.in_ready (in_ready),
		.seed     (seed),
		.push     (push),
		.rec      (rec)
	);

	desp_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rec      (rec),
		.in_ready (in_ready),
		.records  (records)
	);

endmodule
